// ===== src/bfmp_pkg.sv =====
package bfmp_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [3:0]  level;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [7:0]  out_alpha;
      logic        run_last;
      logic        chain_done;
   } rsp_type;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_EVAL,
      ST_EMIT
   } state_type;

endpackage

// ===== src/box_filter_mipmap_pyramid_core.sv =====
// Streaming 2x2 box-filter mipmap generator.
// req_ channel: level-0 RGBA8 pixels in raster order, one transfer per pixel.
// rsp_ channel: one transfer per produced lower-level pixel, carrying level,
//   position, the averaged channels, run_last on the final result of a pixel
//   and chain_done on the last pixel of the final level (1x1 or the level limit).
// csr_ port: index 0 writes the width, index 1 the height; a write restarts
//   the frame. Write only while the block is idle.
// Input transfers go into a four-deep queue; the back end walks the levels
//   one at a time. A pixel ending at a held left column passes the load step
//   only; each level it reaches passes load, line-buffer read, average and
//   emit, and a walk that ends in a line-buffer write also passes the read
//   step. A new pixel is taken from the queue only once the last walk ends.
// A result's run_last is known only when its pixel's walk finishes, so each
//   result is held until the next result is formed or the walk ends.
// When the receiver stalls, the emit step holds, then the queue fills and
//   req_ready drops. Reset clears counters, held pixels and the queue and
//   sets a 256x256 size; the line buffer needs no clearing.
module box_filter_mipmap_pyramid_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_LEVELS = 12,
   parameter int CHANNELS   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfmp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfmp_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_data
);
   logic [12:0] width_ff, height_ff;
   logic        restart;
   logic        q_valid, q_ready;
   bfmp_pkg::req_type q_data;

   // restart the frame on any write to a known register
   assign restart = csr_write &&
      (csr_index == bfmp_pkg::CSR_WIDTH || csr_index == bfmp_pkg::CSR_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd256;
         height_ff <= 13'd256;
      end else if (csr_write) begin
         if (csr_index == bfmp_pkg::CSR_WIDTH) width_ff <= csr_data;
         if (csr_index == bfmp_pkg::CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   bfmp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   bfmp_engine #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_LEVELS(MAX_LEVELS), .CHANNELS(CHANNELS)
   ) u_engine (
      .clock(clock), .reset(reset), .restart(restart),
      .width_cfg(width_ff), .height_cfg(height_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp_data)
   );
endmodule

// ===== src/bfmp_queue.sv =====
module bfmp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bfmp_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output bfmp_pkg::req_type out_data
);
   bfmp_pkg::req_type mem_ff [4];
   logic [2:0] wr_ff, rd_ff;
   logic [2:0] wr_in, rd_in;
   logic       push, pop;

   assign in_ready  = (wr_ff - rd_ff) != 3'd4;
   assign out_valid = wr_ff != rd_ff;
   assign out_data  = mem_ff[rd_ff[1:0]];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign wr_in = wr_ff + {2'd0, push};
   assign rd_in = rd_ff + {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push) mem_ff[wr_ff[1:0]] <= in_data;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) <= 3'd4) else $error("queue count out of range");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((wr_ff - rd_ff) == 3'd4) |-> !in_ready) else $error("full queue takes data");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> rd_ff == $past(rd_ff) + 3'd1) else $error("pop lost");
`endif
endmodule

// ===== src/bfmp_engine.sv =====
module bfmp_engine #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_LEVELS = 12,
   parameter int CHANNELS   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [12:0]       width_cfg,
   input  logic [12:0]       height_cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  bfmp_pkg::req_type in_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfmp_pkg::rsp_type rsp
);
   localparam int LW  = $clog2(MAX_LEVELS + 1);
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 1);
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int BW  = CW + 1;

   bfmp_pkg::state_type state_ff, state_in;

   logic [9:0]  line_ff [MAX_WIDTH][4];
   logic [9:0]  rd_ff [4];
   logic [7:0]  held_ff [MAX_LEVELS][4];
   logic [CW-1:0] col_ff [MAX_LEVELS+1];
   logic [RW-1:0] row_ff [MAX_LEVELS+1];

   logic [7:0]    pix_ff [4];
   logic [LW-1:0] lv_ff;
   logic [CW-1:0] w_ff, x_ff;
   logic [RW-1:0] h_ff, y_ff;
   logic [BW-1:0] base_ff;
   logic [9:0]    hs_ff [4];
   logic          emitted_ff;
   bfmp_pkg::rsp_type out_ff;
   logic          out_valid_ff;

   logic [CW-1:0] wc, w2;
   logic [RW-1:0] hc, h2;
   logic [BW-1:0] idx;
   logic          idx_ok, stop, even_x, even_y;
   logic [9:0]    hs_c [4];
   logic [11:0]   sum_c [4];
   logic [7:0]    avg_c [4];
   logic          last_level, last_pix;

   always_comb begin
      wc = (width_cfg == 13'd0) ? CW'(1) :
           (32'(width_cfg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_cfg);
      hc = (height_cfg == 13'd0) ? RW'(1) :
           (32'(height_cfg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_cfg);
      w2 = (w_ff >= CW'(2)) ? (w_ff >> 1) : CW'(1);
      h2 = (h_ff >= RW'(2)) ? (h_ff >> 1) : RW'(1);
      idx = base_ff + BW'(x_ff >> 1);
      idx_ok = idx < BW'(MAX_WIDTH);
      even_x = !x_ff[0];
      even_y = !y_ff[0];
      stop = (32'(lv_ff) >= MAX_LEVELS) || (w_ff == CW'(1) && h_ff == RW'(1)) ||
             ((w_ff >= CW'(2)) ? (x_ff >= (w2 << 1)) : (x_ff >= CW'(1))) ||
             ((h_ff >= RW'(2)) ? (y_ff >= (h2 << 1)) : (y_ff >= RW'(1)));
      for (int c = 0; c < 4; c++) begin
         hs_c[c] = (w_ff == CW'(1)) ? {1'b0, pix_ff[c], 1'b0} :
                   10'(held_ff[lv_ff[LW-1:0] - LW'(0)][c]) + 10'(pix_ff[c]);
         sum_c[c] = (h_ff == RW'(1)) ? {1'b0, hs_ff[c], 1'b0} :
                    12'(hs_ff[c]) + (idx_ok ? 12'(rd_ff[c]) : 12'd0);
         avg_c[c] = (c < CHANNELS) ? 8'((sum_c[c] + 12'd2) >> 2) : 8'd0;
      end
      last_level = (32'(lv_ff) + 1 >= MAX_LEVELS) || (w2 == CW'(1) && h2 == RW'(1));
      last_pix = (col_ff[lv_ff + LW'(1)] == w2 - CW'(1)) &&
                 (row_ff[lv_ff + LW'(1)] == h2 - RW'(1));
   end

   // sequencer: one level per LOAD/READ/EVAL pass, EMIT holds for output slot
   always_comb begin
      state_in = state_ff;
      in_ready = 1'b0;
      case (state_ff)
         bfmp_pkg::ST_IDLE: begin
            in_ready = !restart;
            if (in_valid && !restart) state_in = bfmp_pkg::ST_LOAD;
         end
         bfmp_pkg::ST_LOAD: begin
            if (stop || (w_ff != CW'(1) && even_x)) state_in = bfmp_pkg::ST_IDLE;
            else state_in = bfmp_pkg::ST_READ;
         end
         bfmp_pkg::ST_READ: begin
            if (h_ff != RW'(1) && even_y) state_in = bfmp_pkg::ST_IDLE;
            else state_in = bfmp_pkg::ST_EVAL;
         end
         bfmp_pkg::ST_EVAL: state_in = bfmp_pkg::ST_EMIT;
         bfmp_pkg::ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) state_in = bfmp_pkg::ST_LOAD;
         end
         default: state_in = bfmp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bfmp_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   logic fire_emit, fin;
   assign fire_emit = (state_ff == bfmp_pkg::ST_EMIT) && (!out_valid_ff || rsp_ready);
   assign fin = (state_ff == bfmp_pkg::ST_LOAD) && (stop || (w_ff != CW'(1) && even_x)) ||
                (state_ff == bfmp_pkg::ST_READ) && (h_ff != RW'(1) && even_y);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int l = 0; l <= MAX_LEVELS; l++) begin
            col_ff[l] <= '0;
            row_ff[l] <= '0;
         end
         for (int l = 0; l < MAX_LEVELS; l++)
            for (int c = 0; c < 4; c++) held_ff[l][c] <= '0;
      end else begin
         case (state_ff)
            bfmp_pkg::ST_IDLE: if (in_valid) begin
               if (col_ff[0] + CW'(1) >= wc) begin
                  col_ff[0] <= '0;
                  row_ff[0] <= (row_ff[0] + RW'(1) >= hc) ? '0 : row_ff[0] + RW'(1);
               end else col_ff[0] <= col_ff[0] + CW'(1);
            end
            bfmp_pkg::ST_LOAD: if (!stop && w_ff != CW'(1) && even_x)
               for (int c = 0; c < 4; c++) held_ff[lv_ff][c] <= pix_ff[c];
            bfmp_pkg::ST_EMIT: if (fire_emit) begin
               if (col_ff[lv_ff + LW'(1)] + CW'(1) >= w2) begin
                  col_ff[lv_ff + LW'(1)] <= '0;
                  row_ff[lv_ff + LW'(1)] <= (row_ff[lv_ff + LW'(1)] + RW'(1) >= h2) ?
                     '0 : row_ff[lv_ff + LW'(1)] + RW'(1);
               end else col_ff[lv_ff + LW'(1)] <= col_ff[lv_ff + LW'(1)] + CW'(1);
            end
            default: ;
         endcase
      end
   end

   // working item registers and line buffer
   always_ff @(posedge clock) begin
      case (state_ff)
         bfmp_pkg::ST_IDLE: begin
            pix_ff[0] <= in_data.red;
            pix_ff[1] <= in_data.green;
            pix_ff[2] <= in_data.blue;
            pix_ff[3] <= in_data.alpha;
            lv_ff <= '0;
            w_ff <= wc;
            h_ff <= hc;
            x_ff <= col_ff[0];
            y_ff <= row_ff[0];
            base_ff <= '0;
            emitted_ff <= 1'b0;
         end
         bfmp_pkg::ST_LOAD: hs_ff <= hs_c;
         bfmp_pkg::ST_READ: begin
            if (h_ff != RW'(1) && even_y && idx_ok)
               line_ff[idx[AW-1:0]] <= hs_ff;
            rd_ff <= line_ff[idx[AW-1:0]];
         end
         bfmp_pkg::ST_EVAL: begin
            pix_ff <= avg_c;
         end
         bfmp_pkg::ST_EMIT: if (fire_emit) begin
            x_ff <= col_ff[lv_ff + LW'(1)];
            y_ff <= row_ff[lv_ff + LW'(1)];
            base_ff <= base_ff + BW'(w2);
            w_ff <= w2;
            h_ff <= h2;
            lv_ff <= lv_ff + LW'(1);
            emitted_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   // output register; run_last is set on the pending result once the pass ends
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (fire_emit) out_valid_ff <= 1'b1;
      else if (rsp_valid && rsp_ready) out_valid_ff <= 1'b0;
      if (fire_emit) begin
         out_ff.level <= 4'(lv_ff + LW'(1));
         out_ff.pos_x <= 11'(col_ff[lv_ff + LW'(1)]);
         out_ff.pos_y <= 11'(row_ff[lv_ff + LW'(1)]);
         out_ff.out_red <= pix_ff[0];
         out_ff.out_green <= pix_ff[1];
         out_ff.out_blue <= pix_ff[2];
         out_ff.out_alpha <= pix_ff[3];
         out_ff.run_last <= 1'b0;
         out_ff.chain_done <= last_level && last_pix;
      end else if (fin && emitted_ff) out_ff.run_last <= 1'b1;
   end

   // hold the last result of a pass until its run_last is known
   logic hold_last;
   assign hold_last = out_valid_ff && !out_ff.run_last &&
                      state_ff != bfmp_pkg::ST_EMIT;
   assign rsp_valid = out_valid_ff && !hold_last;
   assign rsp = out_ff;

`ifndef SYNTHESIS
   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfmp_pkg::ST_EMIT && out_valid_ff && !rsp_ready)
      |=> state_ff == bfmp_pkg::ST_EMIT) else $error("emit did not wait");
   a_idle_only_in: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> state_ff == bfmp_pkg::ST_IDLE) else $error("ready outside idle");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.level != 4'd0)) else $error("level zero emitted");
`endif
endmodule

// ===== test/tb_top.sv =====
module tb_top;

   localparam int LINE_DEPTH   = 4096;
   localparam int LEVEL_LIMIT  = 12;
   localparam int SETTLE       = 100;    // margin for a walk through all levels
   localparam int STALL_LIMIT  = 4000;   // cycles without any transfer
   localparam int SQUEEZE_LEN  = 300;

   // Running model of the mip pyramid: level counters, held even columns
   // and the even-row line buffer, plus the queue of pixels still owed.
   class mip_scoreboard;
      int                  size_w;
      int                  size_h;
      logic [15:0]         row_sums[LINE_DEPTH][4];
      logic [7:0]          held_px[LEVEL_LIMIT][4];
      int                  col_at[LEVEL_LIMIT + 1];
      int                  row_at[LEVEL_LIMIT + 1];
      bfmp_pkg::rsp_type   owed[$];
      int                  mismatches;
      int                  unexpected;

      function new();
         size_w = 256;
         size_h = 256;
         mismatches = 0;
         unexpected = 0;
         restart();
      endfunction

      function void restart();
         foreach (held_px[i, c]) held_px[i][c] = '0;
         foreach (col_at[i]) begin
            col_at[i] = 0;
            row_at[i] = 0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [12:0] val);
         if (idx == bfmp_pkg::CSR_WIDTH) size_w = val;
         else if (idx == bfmp_pkg::CSR_HEIGHT) size_h = val;
         else return;
         restart();
      endfunction

      function int clamp(int v, int maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function void step_pos(int lv, int w, int h);
         col_at[lv]++;
         if (col_at[lv] >= w) begin
            col_at[lv] = 0;
            row_at[lv]++;
            if (row_at[lv] >= h) row_at[lv] = 0;
         end
      endfunction

      // Push the pixels that one level-0 transfer completes, lowest level first.
      function void note_pixel(bfmp_pkg::req_type d);
         logic [7:0]  px[4];
         logic [15:0] hs[4];
         logic [15:0] sm[4];
         int          w, h, w2, h2, base, x, y, lv, idx, ox, oy, n;
         bfmp_pkg::rsp_type r;
         px[0] = d.red;
         px[1] = d.green;
         px[2] = d.blue;
         px[3] = d.alpha;
         w = clamp(size_w, LINE_DEPTH);
         h = clamp(size_h, LINE_DEPTH);
         base = 0;
         lv = 0;
         n = 0;
         x = col_at[0];
         y = row_at[0];
         step_pos(0, w, h);
         while (lv < LEVEL_LIMIT && !(w == 1 && h == 1)) begin
            w2 = (w >= 2) ? w / 2 : 1;
            h2 = (h >= 2) ? h / 2 : 1;
            if (x >= ((w >= 2) ? 2 * w2 : 1) || y >= ((h >= 2) ? 2 * h2 : 1)) break;
            if (w == 1) begin
               for (int c = 0; c < 4; c++) hs[c] = 2 * px[c];
            end else if (x % 2 == 0) begin
               for (int c = 0; c < 4; c++) held_px[lv][c] = px[c];
               break;
            end else begin
               for (int c = 0; c < 4; c++) hs[c] = held_px[lv][c] + px[c];
            end
            idx = base + x / 2;
            if (h == 1) begin
               for (int c = 0; c < 4; c++) sm[c] = 2 * hs[c];
            end else if (y % 2 == 0) begin
               if (idx < LINE_DEPTH)
                  for (int c = 0; c < 4; c++) row_sums[idx][c] = hs[c];
               break;
            end else begin
               for (int c = 0; c < 4; c++)
                  sm[c] = hs[c] + ((idx < LINE_DEPTH) ? row_sums[idx][c] : 16'd0);
            end
            for (int c = 0; c < 4; c++) px[c] = (sm[c] + 16'd2) >> 2;
            ox = col_at[lv + 1];
            oy = row_at[lv + 1];
            step_pos(lv + 1, w2, h2);
            r.level      = lv + 1;
            r.pos_x      = ox;
            r.pos_y      = oy;
            r.out_red    = px[0];
            r.out_green  = px[1];
            r.out_blue   = px[2];
            r.out_alpha  = px[3];
            r.run_last   = 1'b0;
            r.chain_done = (lv + 1 >= LEVEL_LIMIT || (w2 == 1 && h2 == 1))
                           && ox == w2 - 1 && oy == h2 - 1;
            owed.push_back(r);
            n++;
            base += w2;
            w = w2;
            h = h2;
            x = ox;
            y = oy;
            lv++;
         end
         if (n > 0) owed[$].run_last = 1'b1;
      endfunction

      function void check(bfmp_pkg::rsp_type got);
         bfmp_pkg::rsp_type want;
         if (owed.size() == 0) begin
            unexpected++;
            if (unexpected + mismatches <= 10)
               $display("unexpected result %h", got);
            return;
         end
         want = owed.pop_front();
         if (got.level !== want.level || got.pos_x !== want.pos_x
             || got.pos_y !== want.pos_y || got.out_red !== want.out_red
             || got.out_green !== want.out_green || got.out_blue !== want.out_blue
             || got.out_alpha !== want.out_alpha || got.run_last !== want.run_last
             || got.chain_done !== want.chain_done) begin
            mismatches++;
            if (unexpected + mismatches <= 10)
               $display("mismatch: lvl %0d/%0d x %0d/%0d y %0d/%0d rgba %h/%h last %b/%b done %b/%b",
                        want.level, got.level, want.pos_x, got.pos_x, want.pos_y, got.pos_y,
                        {want.out_red, want.out_green, want.out_blue, want.out_alpha},
                        {got.out_red, got.out_green, got.out_blue, got.out_alpha},
                        want.run_last, got.run_last, want.chain_done, got.chain_done);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bfmp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bfmp_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = bfmp_pkg::CSR_WIDTH;
   logic [12:0]       csr_data = '0;

   mip_scoreboard sb = new();
   bit  calm = 1'b0;          // last part of the run: no idling on either side
   bit  squeeze_req = 1'b0;   // sender asks for one long receiver hold-off
   bit  squeeze_taken = 1'b0;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   always #1 clock = ~clock;

   box_filter_mipmap_pyramid_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Result side: check every transfer, then pick ready for the next cycle.
   // Stalls come in bursts; the long hold-off lets the block back up into
   // its input queue until req_ready drops.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (squeeze_req && !squeeze_taken) begin
         squeeze_taken <= 1'b1;
         stall_left    <= SQUEEZE_LEN - 1;
         rsp_ready     <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 11) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: count cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one pixel and hold it until the block takes it; then maybe go
   // quiet for a burst. Valid is lowered only when a gap really follows.
   task automatic send_pixel(bfmp_pkg::req_type d);
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(d);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Drain all owed results, give the back end time to finish any walk that
   // ends without a result, then write one register.
   task automatic write_size(logic [1:0] idx, logic [12:0] val);
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_write <= 1'b0;
   endtask

   task automatic random_frame(logic [12:0] w, logic [12:0] h, int count);
      bfmp_pkg::req_type d;
      write_size(bfmp_pkg::CSR_WIDTH, w);
      write_size(bfmp_pkg::CSR_HEIGHT, h);
      for (int i = 0; i < count; i++) begin
         d = $urandom;
         // bias some channels to the rails so rounding at both ends shows up
         if ($urandom_range(0, 7) == 0) d.red = '1;
         if ($urandom_range(0, 7) == 0) d.alpha = '0;
         send_pixel(d);
      end
   endtask

   initial begin
      bfmp_pkg::req_type corners[6];
      corners[0] = 32'h0000_0000;
      corners[1] = 32'hFFFF_FFFF;
      corners[2] = 32'h01FF_807F;
      corners[3] = 32'hFE01_0203;
      corners[4] = 32'hAA55_00FF;
      corners[5] = 32'h55AA_FF00;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size 256x256: first row only fills line buffers
      for (int i = 0; i < 4; i++) send_pixel(corners[i]);
      // 2x2: one chain-closing pixel from the extremes
      write_size(bfmp_pkg::CSR_WIDTH, 13'd2);
      write_size(bfmp_pkg::CSR_HEIGHT, 13'd2);
      for (int i = 0; i < 4; i++) send_pixel(corners[i]);
      // 1x1 makes nothing
      write_size(bfmp_pkg::CSR_WIDTH, 13'd1);
      write_size(bfmp_pkg::CSR_HEIGHT, 13'd1);
      send_pixel(corners[1]);
      send_pixel(corners[4]);
      // zero width taken as 1, oversize height clamped: single column pairs with itself
      write_size(bfmp_pkg::CSR_WIDTH, 13'd0);
      write_size(bfmp_pkg::CSR_HEIGHT, 13'h1FFF);
      for (int i = 0; i < 4; i++) send_pixel(corners[i + 2]);
      // oversize width clamped, zero height taken as 1: single row
      write_size(bfmp_pkg::CSR_WIDTH, 13'h1FFF);
      write_size(bfmp_pkg::CSR_HEIGHT, 13'd0);
      for (int i = 0; i < 6; i++) send_pixel(corners[i]);
      // 3x3: odd last column and row dropped
      write_size(bfmp_pkg::CSR_WIDTH, 13'd3);
      write_size(bfmp_pkg::CSR_HEIGHT, 13'd3);
      for (int i = 0; i < 9; i++) send_pixel(corners[i % 6]);

      random_frame(13'd4, 13'd4, 16);     // one full frame
      random_frame(13'd5, 13'd7, 20);
      random_frame(13'd1, 13'd6, 6);
      random_frame(13'd7, 13'd1, 7);
      squeeze_req = 1'b1;                 // receiver holds off while pixels keep coming
      random_frame(13'd8, 13'd8, 24);
      random_frame(13'd4096, 13'd2, 8);
      calm = 1'b1;
      random_frame(13'd8, 13'd2, 16);

      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.mismatches == 0 && sb.unexpected == 0 && sb.owed.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
